// ===== design/vector_draw_command_encoder_unit_macros.svh =====
// Assertion macros shared by the vector draw command encoder RTL.
// Included by the modules that carry concurrent assertions.
`ifndef VECTOR_DRAW_COMMAND_ENCODER_UNIT_MACROS_SVH
`define VECTOR_DRAW_COMMAND_ENCODER_UNIT_MACROS_SVH

// same-cycle implication, disabled in reset
`define VDCE_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled in reset
`define VDCE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/vdce_pkg.sv =====
// Types, constants and helper functions of the vector draw command encoder.
// No dependencies; used by every other RTL file but the assertion macro header.
`default_nettype none
package vdce_pkg;
	localparam int NUM_LINKS = 6;
	localparam int MAX_BYTES = 9;
	localparam int COORD_W   = 12;
	localparam int BEAM_W    = 11;
	localparam int LINK_W    = 3;
	localparam int LEN_W     = 4;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [BEAM_W-1:0]  beam_t;
	typedef logic [7:0]                byte_t;
	typedef logic [LINK_W-1:0]         link_t;
	typedef logic [LEN_W-1:0]          len_t;

	localparam logic KIND_POINT = 1'b0;
	localparam logic KIND_LINE  = 1'b1;

	localparam byte_t OP_POINT_ABS = 8'd2;
	localparam byte_t OP_LINE_ABS  = 8'd3;
	localparam byte_t OP_LINE_REL  = 8'd4;
	localparam byte_t OP_POINT_REL = 8'd5;

	localparam len_t LEN_REL       = 4'd3;
	localparam len_t LEN_POINT_ABS = 4'd5;
	localparam len_t LEN_LINE_ABS  = 4'd9;

	localparam beam_t BEAM_RESET = '1;

	typedef struct packed {
		logic   kind;
		link_t  link_index;
		coord_t start_x;
		coord_t start_y;
		coord_t end_x;
		coord_t end_y;
		logic   link_up;
		logic   queue_nearly_full;
	} item_t;

	typedef struct packed {
		link_t                   link;
		byte_t [MAX_BYTES-1:0]   bytes;
		len_t                    len;
	} cmd_t;

	function automatic logic on_screen(input coord_t v);
		return (v[COORD_W-1:10] == '0);
	endfunction

	function automatic logic fits_byte(input coord_t d);
		return (d[COORD_W-1:7] == '0) || (d[COORD_W-1:7] == '1);
	endfunction

	function automatic byte_t high_byte(input coord_t v);
		return {6'd0, v[9:8]};
	endfunction
endpackage
`default_nettype wire

// ===== design/vdce_draw_if.sv =====
// Draw request channel: valid/ready handshake with the request payload.
// Depends on vdce_pkg.
`default_nettype none
interface vdce_draw_if;
	logic                   valid;
	logic                   ready;
	logic                   kind;
	vdce_pkg::link_t        link_index;
	vdce_pkg::coord_t       start_x;
	vdce_pkg::coord_t       start_y;
	vdce_pkg::coord_t       end_x;
	vdce_pkg::coord_t       end_y;
	logic                   link_up;
	logic                   queue_nearly_full;

	modport source (output valid, kind, link_index, start_x, start_y, end_x, end_y,
		link_up, queue_nearly_full, input ready);
	modport sink (input valid, kind, link_index, start_x, start_y, end_x, end_y,
		link_up, queue_nearly_full, output ready);
endinterface
`default_nettype wire

// ===== design/vdce_byte_if.sv =====
// Command byte channel: valid/ready handshake with link, byte and last flag.
// Depends on vdce_pkg.
`default_nettype none
interface vdce_byte_if;
	logic            valid;
	logic            ready;
	vdce_pkg::link_t out_link;
	vdce_pkg::byte_t out_byte;
	logic            last_byte;

	modport source (output valid, out_link, out_byte, last_byte, input ready);
	modport sink (input valid, out_link, out_byte, last_byte, output ready);
endinterface
`default_nettype wire

// ===== design/vector_draw_command_encoder_unit.sv =====
// Top level of the vector draw command encoder.
// Depends on vdce_pkg, vdce_draw_if, vdce_byte_if, vdce_encoder, vdce_serializer.
//
// draw: one transaction per point or line request. tx: one transaction per
// command byte, tagged with its link; last_byte marks the final byte.
// A kept request becomes a 3-, 5- or 9-byte command; a request for a link out
// of range, a down link, a nearly full queue or an off-screen coordinate is
// dropped without output and without moving the beam.
// The first byte of a command moves via the input register and command buffer
// into the output register, then one byte per cycle while tx.ready is high.
// Throughput: the single byte port sets the rate for kept requests, whose commands
// go out byte by byte; dropped ones are taken one per cycle. The next request
// is taken into the input register while the current command still drains.
// Reset puts the shared beam position at -1,-1 and empties all stages.
// When the receiver stalls, the output byte holds, the command buffer and the
// input register fill, and draw.ready falls until bytes move again.
`default_nettype none
module vector_draw_command_encoder_unit (
	input  wire logic clk,
	input  wire logic arst_n,
	vdce_draw_if.sink   draw,
	vdce_byte_if.source tx
);
	vdce_pkg::cmd_t cmd;
	logic           cmd_valid;
	logic           cmd_ready;

	vdce_encoder u_encoder (
		.clk       (clk),
		.arst_n    (arst_n),
		.draw      (draw),
		.cmd       (cmd),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready)
	);

	vdce_serializer u_serializer (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.tx        (tx)
	);
endmodule
`default_nettype wire

// ===== design/vdce_encoder.sv =====
// Input register, beam position registers and command encode logic.
// Depends on vdce_pkg and vdce_draw_if.
`default_nettype none
module vdce_encoder (
	input  wire logic           clk,
	input  wire logic           arst_n,
	vdce_draw_if.sink           draw,
	output vdce_pkg::cmd_t      cmd,
	output logic                cmd_valid,
	input  wire logic           cmd_ready
);
	logic            valid_s1;
	vdce_pkg::item_t item_s1;
	vdce_pkg::beam_t beam_x_q;
	vdce_pkg::beam_t beam_y_q;

	vdce_pkg::coord_t bx, by, dx_pt, dy_pt, dx_ln, dy_ln;
	logic             drop, advance, pt_rel, ln_rel, link_bad;

	assign link_bad = {1'b0, item_s1.link_index} >= (vdce_pkg::LINK_W+1)'(vdce_pkg::NUM_LINKS);
	assign bx    = {beam_x_q[vdce_pkg::BEAM_W-1], beam_x_q};
	assign by    = {beam_y_q[vdce_pkg::BEAM_W-1], beam_y_q};
	assign dx_pt = item_s1.start_x - bx;
	assign dy_pt = item_s1.start_y - by;
	assign dx_ln = item_s1.end_x - item_s1.start_x;
	assign dy_ln = item_s1.end_y - item_s1.start_y;
	assign pt_rel = vdce_pkg::fits_byte(dx_pt) && vdce_pkg::fits_byte(dy_pt);
	assign ln_rel = (item_s1.start_x == bx) && (item_s1.start_y == by)
		&& vdce_pkg::fits_byte(dx_ln) && vdce_pkg::fits_byte(dy_ln);

	always_comb begin
		drop = link_bad || !item_s1.link_up || item_s1.queue_nearly_full
			|| !vdce_pkg::on_screen(item_s1.start_x) || !vdce_pkg::on_screen(item_s1.start_y);
		if (item_s1.kind == vdce_pkg::KIND_LINE) begin
			drop = drop || !vdce_pkg::on_screen(item_s1.end_x)
				|| !vdce_pkg::on_screen(item_s1.end_y);
		end
	end

	always_comb begin
		cmd.link  = item_s1.link_index;
		cmd.bytes = '0;
		if (item_s1.kind == vdce_pkg::KIND_POINT) begin
			if (pt_rel) begin
				cmd.len      = vdce_pkg::LEN_REL;
				cmd.bytes[0] = vdce_pkg::OP_POINT_REL;
				cmd.bytes[1] = dx_pt[7:0];
				cmd.bytes[2] = dy_pt[7:0];
			end else begin
				cmd.len      = vdce_pkg::LEN_POINT_ABS;
				cmd.bytes[0] = vdce_pkg::OP_POINT_ABS;
				cmd.bytes[1] = vdce_pkg::high_byte(item_s1.start_x);
				cmd.bytes[2] = item_s1.start_x[7:0];
				cmd.bytes[3] = vdce_pkg::high_byte(item_s1.start_y);
				cmd.bytes[4] = item_s1.start_y[7:0];
			end
		end else begin
			if (ln_rel) begin
				cmd.len      = vdce_pkg::LEN_REL;
				cmd.bytes[0] = vdce_pkg::OP_LINE_REL;
				cmd.bytes[1] = dx_ln[7:0];
				cmd.bytes[2] = dy_ln[7:0];
			end else begin
				cmd.len      = vdce_pkg::LEN_LINE_ABS;
				cmd.bytes[0] = vdce_pkg::OP_LINE_ABS;
				cmd.bytes[1] = vdce_pkg::high_byte(item_s1.start_x);
				cmd.bytes[2] = item_s1.start_x[7:0];
				cmd.bytes[3] = vdce_pkg::high_byte(item_s1.start_y);
				cmd.bytes[4] = item_s1.start_y[7:0];
				cmd.bytes[5] = vdce_pkg::high_byte(item_s1.end_x);
				cmd.bytes[6] = item_s1.end_x[7:0];
				cmd.bytes[7] = vdce_pkg::high_byte(item_s1.end_y);
				cmd.bytes[8] = item_s1.end_y[7:0];
			end
		end
	end

	assign cmd_valid  = valid_s1 && !drop;
	assign advance    = valid_s1 && (drop || cmd_ready);
	assign draw.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			beam_x_q <= vdce_pkg::BEAM_RESET;
			beam_y_q <= vdce_pkg::BEAM_RESET;
		end else begin
			if (draw.ready) begin
				valid_s1 <= draw.valid;
			end
			if (cmd_valid && cmd_ready) begin
				if (item_s1.kind == vdce_pkg::KIND_LINE) begin
					beam_x_q <= item_s1.end_x[vdce_pkg::BEAM_W-1:0];
					beam_y_q <= item_s1.end_y[vdce_pkg::BEAM_W-1:0];
				end else begin
					beam_x_q <= item_s1.start_x[vdce_pkg::BEAM_W-1:0];
					beam_y_q <= item_s1.start_y[vdce_pkg::BEAM_W-1:0];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (draw.ready && draw.valid) begin
			item_s1.kind              <= draw.kind;
			item_s1.link_index        <= draw.link_index;
			item_s1.start_x           <= draw.start_x;
			item_s1.start_y           <= draw.start_y;
			item_s1.end_x             <= draw.end_x;
			item_s1.end_y             <= draw.end_y;
			item_s1.link_up           <= draw.link_up;
			item_s1.queue_nearly_full <= draw.queue_nearly_full;
		end
	end
endmodule
`default_nettype wire

// ===== design/vdce_serializer.sv =====
// Command buffer and byte serializer with a registered output stage.
// Depends on vdce_pkg, vdce_byte_if and the assertion macro header.
`default_nettype none
`include "vector_draw_command_encoder_unit_macros.svh"
module vdce_serializer (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire vdce_pkg::cmd_t cmd,
	input  wire logic           cmd_valid,
	output logic                cmd_ready,
	vdce_byte_if.source         tx
);
	logic                                 busy_q;
	vdce_pkg::len_t                       idx_q;
	vdce_pkg::len_t                       len_q;
	vdce_pkg::link_t                      link_q;
	vdce_pkg::byte_t [vdce_pkg::MAX_BYTES-1:0] bytes_q;
	logic                                 out_valid_q;
	vdce_pkg::link_t                      out_link_q;
	vdce_pkg::byte_t                      out_byte_q;
	logic                                 out_last_q;

	logic out_free, emit, at_last, load;

	assign out_free  = !out_valid_q || tx.ready;
	assign emit      = busy_q && out_free;
	assign at_last   = (idx_q == len_q - vdce_pkg::len_t'(1));
	assign cmd_ready = !busy_q || (emit && at_last);
	assign load      = cmd_valid && cmd_ready;

	assign tx.valid     = out_valid_q;
	assign tx.out_link  = out_link_q;
	assign tx.out_byte  = out_byte_q;
	assign tx.last_byte = out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_free) begin
				out_valid_q <= emit;
			end
			if (load) begin
				busy_q <= 1'b1;
				idx_q  <= '0;
			end else if (emit && at_last) begin
				busy_q <= 1'b0;
			end else if (emit) begin
				idx_q <= idx_q + vdce_pkg::len_t'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			bytes_q <= cmd.bytes;
			len_q   <= cmd.len;
			link_q  <= cmd.link;
		end
		if (emit) begin
			out_link_q <= link_q;
			out_byte_q <= bytes_q[idx_q];
			out_last_q <= at_last;
		end
	end

	`VDCE_ASSERT_NOW(a_idx_in_cmd, clk, arst_n, busy_q, idx_q < len_q, "byte index past command end")
	`VDCE_ASSERT_NOW(a_len_legal, clk, arst_n, busy_q,
		len_q == vdce_pkg::LEN_REL || len_q == vdce_pkg::LEN_POINT_ABS
		|| len_q == vdce_pkg::LEN_LINE_ABS, "illegal command length")
	`VDCE_ASSERT_NOW(a_no_overwrite, clk, arst_n, load, !busy_q || (emit && at_last),
		"command loaded over unfinished command")
	`VDCE_ASSERT_NEXT(a_done_idle, clk, arst_n, emit && at_last && !load, !busy_q,
		"serializer busy after last byte")
endmodule
`default_nettype wire

// ===== verif/vector_draw_command_encoder_unit_test.sv =====
// Self-checking testbench for vector_draw_command_encoder_unit: point and line requests in,
// command bytes out, checked against an in-bench encoder that tracks the shared beam.
// Depends on vdce_pkg, vdce_draw_if, vdce_byte_if and the unit RTL.
`default_nettype none
module vector_draw_command_encoder_unit_test;
	localparam int LIMIT_CYCLES = 200000;

	typedef struct packed {
		vdce_pkg::link_t link;
		vdce_pkg::byte_t value;
		logic            last;
	} tx_beat_t;

	logic clk;
	logic arst_n;

	vdce_draw_if draw ();
	vdce_byte_if tx ();

	vector_draw_command_encoder_unit i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.draw   (draw),
		.tx     (tx)
	);

	tx_beat_t        expected_bytes[$];
	vdce_pkg::beam_t cur_x;
	vdce_pkg::beam_t cur_y;
	int              error_count;
	int              cycle_count;
	int              send_idle_pct;
	int              recv_stall_pct;
	int              hold_left;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic logic visible(input int v);
		return v >= 0 && v <= 1023;
	endfunction

	function automatic logic fits8(input int d);
		return d >= -128 && d <= 127;
	endfunction

	// expected command bytes for one request; advances the beam copy if it is kept
	function automatic int encode_request(input vdce_pkg::item_t it);
		int              x1;
		int              y1;
		int              x2;
		int              y2;
		int              dx;
		int              dy;
		int              len;
		vdce_pkg::byte_t cmd [vdce_pkg::MAX_BYTES];
		x1 = int'(it.start_x);
		y1 = int'(it.start_y);
		x2 = int'(it.end_x);
		y2 = int'(it.end_y);
		if (it.link_index >= vdce_pkg::NUM_LINKS || !it.link_up || it.queue_nearly_full)
			return 0;
		if (!visible(x1) || !visible(y1))
			return 0;
		if (it.kind == vdce_pkg::KIND_POINT) begin
			dx = x1 - int'(cur_x);
			dy = y1 - int'(cur_y);
			if (fits8(dx) && fits8(dy)) begin
				cmd[0] = vdce_pkg::OP_POINT_REL;
				cmd[1] = vdce_pkg::byte_t'(dx);
				cmd[2] = vdce_pkg::byte_t'(dy);
				len = 3;
			end else begin
				cmd[0] = vdce_pkg::OP_POINT_ABS;
				cmd[1] = vdce_pkg::byte_t'(x1 >> 8);
				cmd[2] = vdce_pkg::byte_t'(x1);
				cmd[3] = vdce_pkg::byte_t'(y1 >> 8);
				cmd[4] = vdce_pkg::byte_t'(y1);
				len = 5;
			end
			cur_x = vdce_pkg::beam_t'(x1);
			cur_y = vdce_pkg::beam_t'(y1);
		end else begin
			if (!visible(x2) || !visible(y2))
				return 0;
			dx = x2 - x1;
			dy = y2 - y1;
			if (x1 == int'(cur_x) && y1 == int'(cur_y) && fits8(dx) && fits8(dy)) begin
				cmd[0] = vdce_pkg::OP_LINE_REL;
				cmd[1] = vdce_pkg::byte_t'(dx);
				cmd[2] = vdce_pkg::byte_t'(dy);
				len = 3;
			end else begin
				cmd[0] = vdce_pkg::OP_LINE_ABS;
				cmd[1] = vdce_pkg::byte_t'(x1 >> 8);
				cmd[2] = vdce_pkg::byte_t'(x1);
				cmd[3] = vdce_pkg::byte_t'(y1 >> 8);
				cmd[4] = vdce_pkg::byte_t'(y1);
				cmd[5] = vdce_pkg::byte_t'(x2 >> 8);
				cmd[6] = vdce_pkg::byte_t'(x2);
				cmd[7] = vdce_pkg::byte_t'(y2 >> 8);
				cmd[8] = vdce_pkg::byte_t'(y2);
				len = 9;
			end
			cur_x = vdce_pkg::beam_t'(x2);
			cur_y = vdce_pkg::beam_t'(y2);
		end
		for (int i = 0; i < len; i++)
			expected_bytes.push_back('{it.link_index, cmd[i], (i == len - 1)});
		return len;
	endfunction

	function automatic vdce_pkg::item_t make_request(input logic kind, input int link,
		input int sx, input int sy, input int ex, input int ey, input logic up,
		input logic full);
		vdce_pkg::item_t it;
		it.kind              = kind;
		it.link_index        = vdce_pkg::link_t'(link);
		it.start_x           = vdce_pkg::coord_t'(sx);
		it.start_y           = vdce_pkg::coord_t'(sy);
		it.end_x             = vdce_pkg::coord_t'(ex);
		it.end_y             = vdce_pkg::coord_t'(ey);
		it.link_up           = up;
		it.queue_nearly_full = full;
		return it;
	endfunction

	function automatic int pick_coord(input int base);
		int sel;
		sel = $urandom_range(99);
		if (sel < 45)
			return base + int'($urandom_range(270)) - 135;
		else if (sel < 85)
			return int'($urandom_range(1023));
		else
			return int'($urandom_range(4095)) - 2048;
	endfunction

	function automatic vdce_pkg::item_t random_request();
		logic kind;
		int   link;
		int   sx;
		int   sy;
		kind = 1'($urandom_range(1));
		if ($urandom_range(99) < 8)
			link = $urandom_range(7, 6);
		else
			link = $urandom_range(5, 0);
		if (kind == vdce_pkg::KIND_LINE && $urandom_range(1)) begin
			sx = int'(cur_x);
			sy = int'(cur_y);
		end else begin
			sx = pick_coord(int'(cur_x));
			sy = pick_coord(int'(cur_y));
		end
		return make_request(kind, link, sx, sy, pick_coord(sx), pick_coord(sy),
			$urandom_range(99) >= 6, $urandom_range(99) < 6);
	endfunction

	task automatic send_draw(input vdce_pkg::item_t it, output int nbytes);
		draw.valid             <= 1'b1;
		draw.kind              <= it.kind;
		draw.link_index        <= it.link_index;
		draw.start_x           <= it.start_x;
		draw.start_y           <= it.start_y;
		draw.end_x             <= it.end_x;
		draw.end_y             <= it.end_y;
		draw.link_up           <= it.link_up;
		draw.queue_nearly_full <= it.queue_nearly_full;
		@(posedge clk);
		while (!draw.ready)
			@(posedge clk);
		nbytes = encode_request(it);
		while ($urandom_range(99) < send_idle_pct) begin
			draw.valid <= 1'b0;
			@(posedge clk);
		end
	endtask

	task automatic wait_drained();
		draw.valid <= 1'b0;
		@(posedge clk);
		while (expected_bytes.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_first_draws();
		int n;
		send_draw(make_request(vdce_pkg::KIND_POINT, 0, 0, 0, 0, 0, 1'b1, 1'b0), n);
		send_draw(make_request(vdce_pkg::KIND_POINT, 1, 127, 0, 0, 0, 1'b1, 1'b0), n);
		send_draw(make_request(vdce_pkg::KIND_POINT, 2, 255, 0, 0, 0, 1'b1, 1'b0), n);
		send_draw(make_request(vdce_pkg::KIND_POINT, 3, 127, 0, 0, 0, 1'b1, 1'b0), n);
		send_draw(make_request(vdce_pkg::KIND_POINT, 4, 127, 1023, -2048, 2047, 1'b1, 1'b0),
			n);
		send_draw(make_request(vdce_pkg::KIND_POINT, 5, 1023, 1023, 0, 0, 1'b1, 1'b0), n);
	endtask

	task automatic test_dropped_requests();
		int n;
		send_draw(make_request(vdce_pkg::KIND_POINT, 6, 1000, 1000, 0, 0, 1'b1, 1'b0), n);
		send_draw(make_request(vdce_pkg::KIND_LINE, 7, 1023, 1023, 1000, 1000, 1'b1, 1'b0), n);
		send_draw(make_request(vdce_pkg::KIND_POINT, 2, 1000, 1000, 0, 0, 1'b0, 1'b0), n);
		send_draw(make_request(vdce_pkg::KIND_LINE, 3, 1023, 1023, 1000, 1000, 1'b1, 1'b1), n);
		send_draw(make_request(vdce_pkg::KIND_POINT, 0, 1024, 1000, 0, 0, 1'b1, 1'b0), n);
		send_draw(make_request(vdce_pkg::KIND_POINT, 1, 1000, -1, 0, 0, 1'b1, 1'b0), n);
		send_draw(make_request(vdce_pkg::KIND_POINT, 0, -2048, 2047, 0, 0, 1'b1, 1'b0), n);
		send_draw(make_request(vdce_pkg::KIND_LINE, 4, 1023, 1023, 1024, 1000, 1'b1, 1'b0), n);
		send_draw(make_request(vdce_pkg::KIND_LINE, 5, 1023, 1023, 1000, -1, 1'b1, 1'b0), n);
	endtask

	task automatic test_line_forms();
		int n;
		send_draw(make_request(vdce_pkg::KIND_LINE, 0, 1023, 1023, 895, 1000, 1'b1, 1'b0), n);
		send_draw(make_request(vdce_pkg::KIND_LINE, 1, 895, 1000, 1022, 1023, 1'b1, 1'b0), n);
		send_draw(make_request(vdce_pkg::KIND_LINE, 2, 1022, 1023, 893, 1023, 1'b1, 1'b0), n);
		send_draw(make_request(vdce_pkg::KIND_LINE, 3, 0, 0, 1, 1, 1'b1, 1'b0), n);
		send_draw(make_request(vdce_pkg::KIND_LINE, 4, 1, 1, 1, 129, 1'b1, 1'b0), n);
		send_draw(make_request(vdce_pkg::KIND_LINE, 5, 1, 129, 1, 129, 1'b1, 1'b0), n);
		send_draw(make_request(vdce_pkg::KIND_LINE, 5, 1023, 0, 0, 1023, 1'b1, 1'b0), n);
	endtask

	task automatic test_random_traffic(input int idle_pct, input int stall_pct,
		input int item_count);
		int n;
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		repeat (item_count)
			send_draw(random_request(), n);
		wait_drained();
	endtask

	task automatic test_backpressure();
		int n;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		hold_left      = 150;
		repeat (12)
			send_draw(random_request(), n);
		wait_drained();
	endtask

	always @(posedge clk) begin
		if (hold_left > 0) begin
			tx.ready <= 1'b0;
			hold_left--;
		end else begin
			tx.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		tx_beat_t exp_beat;
		if (arst_n && tx.valid && tx.ready) begin
			if (expected_bytes.size() == 0) begin
				$display("%0t: unexpected byte link %0d byte %h last %b", $time,
					tx.out_link, tx.out_byte, tx.last_byte);
				error_count++;
			end else begin
				exp_beat = expected_bytes.pop_front();
				if (tx.out_link !== exp_beat.link || tx.out_byte !== exp_beat.value
					|| tx.last_byte !== exp_beat.last) begin
					$display("%0t: expected link %0d byte %h last %b, got link %0d byte %h last %b",
						$time, exp_beat.link, exp_beat.value, exp_beat.last,
						tx.out_link, tx.out_byte, tx.last_byte);
					error_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("vector_draw_command_encoder_unit: mismatch");
			$finish;
		end
	end

	initial begin
		arst_n                 = 1'b0;
		error_count            = 0;
		cycle_count            = 0;
		send_idle_pct          = 0;
		recv_stall_pct         = 0;
		hold_left              = 0;
		cur_x                  = vdce_pkg::BEAM_RESET;
		cur_y                  = vdce_pkg::BEAM_RESET;
		draw.valid             = 1'b0;
		draw.kind              = vdce_pkg::KIND_POINT;
		draw.link_index        = '0;
		draw.start_x           = '0;
		draw.start_y           = '0;
		draw.end_x             = '0;
		draw.end_y             = '0;
		draw.link_up           = 1'b0;
		draw.queue_nearly_full = 1'b0;
		repeat (8)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_first_draws();
		test_dropped_requests();
		test_line_forms();
		wait_drained();
		test_random_traffic(0, 0, 19);
		test_random_traffic(48, 0, 19);
		test_random_traffic(0, 48, 19);
		test_backpressure();
		test_random_traffic(21, 21, 19);
		repeat (20)
			@(posedge clk);
		if (error_count == 0)
			$display("vector_draw_command_encoder_unit: match");
		else
			$display("vector_draw_command_encoder_unit: mismatch");
		$finish;
	end
endmodule
`default_nettype wire
